### rtl/core/m3i_pkg.sv
// Shared widths, types and pipeline constants for the 3x3 fixed-point inverse.
package m3i_pkg;

  localparam int ENTRY_WIDTH   = 16;
  localparam int FRACTION_BITS = 16;

  localparam int IN_W    = 16;
  localparam int OUT_W   = 48;
  localparam int PROD_W  = 2 * ENTRY_WIDTH;
  localparam int ADJ_W   = 2 * ENTRY_WIDTH + 1;
  localparam int DPROD_W = ENTRY_WIDTH + ADJ_W;
  localparam int DET_W   = DPROD_W + 2;

  localparam int DIV_STAGES = ADJ_W + FRACTION_BITS;
  localparam int QX_W       = ((DIV_STAGES > OUT_W) ? DIV_STAGES : OUT_W) + 1;
  localparam int LATENCY    = DIV_STAGES + 7;

  typedef logic signed [ENTRY_WIDTH-1:0] entry_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ADJ_W-1:0]       adj_t;
  typedef logic signed [DPROD_W-1:0]     dprod_t;
  typedef logic signed [DET_W-1:0]       det_t;
  typedef logic [DIV_STAGES-1:0]         quo_t;

  typedef struct packed {
    logic valid;
    logic singular;
  } ctl_t;

endpackage

### rtl/core/matrix3x3_inverse_fixed_core.sv
// Top level of the 3x3 fixed-point matrix inverse: cofactor pipeline, nine divider lanes, merge.
//
// channel  | signals                            | dir | handshake
// ---------+------------------------------------+-----+-------------------------------
// matrix   | m11_i .. m33_i                     | in  | start_i && !busy_o
// inverse  | inv11_o .. inv33_o, singular_o     | out | done_o, one cycle, no stall
//
// One beat per cycle sustained; busy_o stays low.
// The restoring divider in each lane resolves one quotient bit per pipeline stage.
// Reset clears only the valid pipeline; data registers are not reset.
// The receiver cannot stall; results leave on done_o unconditionally.
module matrix3x3_inverse_fixed_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [m3i_pkg::IN_W-1:0]     m11_i,
  input  logic signed [m3i_pkg::IN_W-1:0]     m12_i,
  input  logic signed [m3i_pkg::IN_W-1:0]     m13_i,
  input  logic signed [m3i_pkg::IN_W-1:0]     m21_i,
  input  logic signed [m3i_pkg::IN_W-1:0]     m22_i,
  input  logic signed [m3i_pkg::IN_W-1:0]     m23_i,
  input  logic signed [m3i_pkg::IN_W-1:0]     m31_i,
  input  logic signed [m3i_pkg::IN_W-1:0]     m32_i,
  input  logic signed [m3i_pkg::IN_W-1:0]     m33_i,
  output logic                                done_o,
  output logic signed [m3i_pkg::OUT_W-1:0]    inv11_o,
  output logic signed [m3i_pkg::OUT_W-1:0]    inv12_o,
  output logic signed [m3i_pkg::OUT_W-1:0]    inv13_o,
  output logic signed [m3i_pkg::OUT_W-1:0]    inv21_o,
  output logic signed [m3i_pkg::OUT_W-1:0]    inv22_o,
  output logic signed [m3i_pkg::OUT_W-1:0]    inv23_o,
  output logic signed [m3i_pkg::OUT_W-1:0]    inv31_o,
  output logic signed [m3i_pkg::OUT_W-1:0]    inv32_o,
  output logic signed [m3i_pkg::OUT_W-1:0]    inv33_o,
  output logic                                singular_o
);

  localparam int Q  = m3i_pkg::DIV_STAGES;
  localparam int W  = m3i_pkg::OUT_W;
  localparam int QX = m3i_pkg::QX_W;
  localparam logic [QX-1:0] POS_MAX = QX'({1'b0, {(W-1){1'b1}}});
  localparam logic [QX-1:0] NEG_MAX = POS_MAX + QX'(1);

  logic [8:0][m3i_pkg::IN_W-1:0] m;
  logic                          cof_valid;
  m3i_pkg::det_t                 det;
  m3i_pkg::adj_t                 adj [9];
  m3i_pkg::quo_t                 mag [9];
  logic                          neg [9];
  m3i_pkg::ctl_t                 ctl_q [Q+1];
  logic                          done_q;
  logic                          sing_q;
  logic [W-1:0]                  inv_d [9];
  logic [W-1:0]                  inv_q [9];

  assign m = {m33_i, m32_i, m31_i, m23_i, m22_i, m21_i, m13_i, m12_i, m11_i};
  assign busy_o = 1'b0;

  m3i_cof u_cof (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .m_i     (m),
    .valid_o (cof_valid),
    .det_o   (det),
    .adj_o   (adj)
  );

  for (genvar i = 0; i < 9; i++) begin : g_lane
    logic [QX-1:0] magx;
    logic [QX-1:0] lim;

    m3i_lane u_lane (
      .clk_i (clk_i),
      .adj_i (adj[i]),
      .det_i (det),
      .mag_o (mag[i]),
      .neg_o (neg[i])
    );

    assign magx = QX'(mag[i]);

    always_comb begin
      if (neg[i]) begin
        lim      = (magx > NEG_MAX) ? NEG_MAX : magx;
        inv_d[i] = W'(-lim[W-1:0]);
      end else begin
        lim      = (magx > POS_MAX) ? POS_MAX : magx;
        inv_d[i] = lim[W-1:0];
      end
      if (ctl_q[Q].singular) begin
        inv_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Q; k++) begin
        ctl_q[k] <= '0;
      end
      done_q <= 1'b0;
    end else begin
      ctl_q[0] <= '{valid: cof_valid, singular: (det == '0)};
      for (int k = 1; k <= Q; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
      done_q <= ctl_q[Q].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sing_q <= ctl_q[Q].singular;
    inv_q  <= inv_d;
  end

  assign done_o     = done_q;
  assign singular_o = sing_q;
  assign inv11_o    = inv_q[0];
  assign inv12_o    = inv_q[1];
  assign inv13_o    = inv_q[2];
  assign inv21_o    = inv_q[3];
  assign inv22_o    = inv_q[4];
  assign inv23_o    = inv_q[5];
  assign inv31_o    = inv_q[6];
  assign inv32_o    = inv_q[7];
  assign inv33_o    = inv_q[8];

endmodule

### rtl/core/m3i_cof.sv
// Cofactor, adjugate and determinant pipeline (five register stages).
module m3i_cof (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [8:0][m3i_pkg::IN_W-1:0]   m_i,
  output logic                            valid_o,
  output m3i_pkg::det_t                   det_o,
  output m3i_pkg::adj_t                   adj_o [9]
);

  localparam int PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int NA [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int NB [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic [4:0]            v_q;
  m3i_pkg::entry_t       a_q   [9];
  m3i_pkg::prod_t        pp_q  [9];
  m3i_pkg::prod_t        pn_q  [9];
  m3i_pkg::entry_t       ar1_q [3];
  m3i_pkg::entry_t       ar2_q [3];
  m3i_pkg::adj_t         adj2_q [9];
  m3i_pkg::adj_t         adj3_q [9];
  m3i_pkg::adj_t         adj4_q [9];
  m3i_pkg::dprod_t       dp_q  [3];
  m3i_pkg::det_t         det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      a_q[i]    <= m3i_pkg::entry_t'(m_i[i][m3i_pkg::ENTRY_WIDTH-1:0]);
      pp_q[i]   <= a_q[PA[i]] * a_q[PB[i]];
      pn_q[i]   <= a_q[NA[i]] * a_q[NB[i]];
      adj2_q[i] <= m3i_pkg::adj_t'(pp_q[i]) - m3i_pkg::adj_t'(pn_q[i]);
      adj3_q[i] <= adj2_q[i];
      adj4_q[i] <= adj3_q[i];
    end
    for (int j = 0; j < 3; j++) begin
      ar1_q[j] <= a_q[j];
      ar2_q[j] <= ar1_q[j];
      dp_q[j]  <= m3i_pkg::dprod_t'(ar2_q[j]) * m3i_pkg::dprod_t'(adj2_q[3*j]);
    end
    det_q <= m3i_pkg::det_t'(dp_q[0]) + m3i_pkg::det_t'(dp_q[1])
           + m3i_pkg::det_t'(dp_q[2]);
  end

  assign valid_o = v_q[4];
  assign det_o   = det_q;
  assign adj_o   = adj4_q;

endmodule

### rtl/core/m3i_lane.sv
// One divider lane: adjugate entry times 2^F over determinant, one quotient bit per stage.
module m3i_lane (
  input  logic                               clk_i,
  input  m3i_pkg::adj_t                      adj_i,
  input  m3i_pkg::det_t                      det_i,
  output m3i_pkg::quo_t                      mag_o,
  output logic                               neg_o
);

  localparam int Q = m3i_pkg::DIV_STAGES;
  localparam int R = m3i_pkg::DET_W;

  logic [R-1:0] rem_q [Q+1];
  logic [Q-1:0] num_q [Q+1];
  logic [Q-1:0] quo_q [Q+1];
  logic [R-1:0] dm_q  [Q+1];
  logic         neg_q [Q+1];

  logic [m3i_pkg::ADJ_W-1:0] nmag;
  logic [R-1:0]              dmag;

  assign nmag = adj_i[m3i_pkg::ADJ_W-1] ? m3i_pkg::ADJ_W'(-adj_i) : m3i_pkg::ADJ_W'(adj_i);
  assign dmag = det_i[R-1] ? R'(-det_i) : R'(det_i);

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    num_q[0] <= Q'(nmag) << m3i_pkg::FRACTION_BITS;
    quo_q[0] <= '0;
    dm_q[0]  <= dmag;
    neg_q[0] <= adj_i[m3i_pkg::ADJ_W-1] ^ det_i[R-1];
  end

  for (genvar k = 1; k <= Q; k++) begin : g_stage
    logic [R:0] t;
    logic [R:0] diff;
    logic       ge;

    assign t    = {rem_q[k-1], num_q[k-1][Q-1]};
    assign ge   = t >= {1'b0, dm_q[k-1]};
    assign diff = t - {1'b0, dm_q[k-1]};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[R-1:0] : t[R-1:0];
      num_q[k] <= num_q[k-1] << 1;
      quo_q[k] <= {quo_q[k-1][Q-2:0], ge};
      dm_q[k]  <= dm_q[k-1];
      neg_q[k] <= neg_q[k-1];
    end
  end

  assign mag_o = quo_q[Q];
  assign neg_o = neg_q[Q];

endmodule

### rtl/core/m3i_checker.sv
// Port-level checker for the 3x3 inverse core, bound to the top level.
module m3i_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic                             done_o,
  input logic                             singular_o,
  input logic [m3i_pkg::OUT_W-1:0]        inv11_o,
  input logic [m3i_pkg::OUT_W-1:0]        inv22_o,
  input logic [m3i_pkg::OUT_W-1:0]        inv33_o
);

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(m3i_pkg::LATENCY) done_o)
    else $error("result beat missing");

  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, m3i_pkg::LATENCY))
    else $error("result beat without request");

  a_sing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && singular_o) |-> (inv11_o == '0 && inv22_o == '0 && inv33_o == '0))
    else $error("singular beat with nonzero entries");

endmodule

bind matrix3x3_inverse_fixed_core m3i_checker u_m3i_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .singular_o (singular_o),
  .inv11_o    (inv11_o),
  .inv22_o    (inv22_o),
  .inv33_o    (inv33_o)
);
